[sv/uts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types and constants of the unaligned transfer splitter: operation
// kinds, operation slot numbering and fixed field widths.
// ----------------------------------------------------------------------------
package uts_pkg;

  // fixed field widths of the request and operation items
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned OPLEN_W = 33;
  localparam int unsigned FLAGS_W = 8;
  localparam int unsigned KIND_W  = 2;

  // packed stream widths
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 144;

  // operation kinds carried on tuser
  typedef enum logic [KIND_W-1:0] {
    OP_NONE      = 2'd0,
    OP_TO_BOUNCE = 2'd1,
    OP_DIRECT    = 2'd2,
    OP_BYTE_COPY = 2'd3
  } op_kind_e;

  // emission slots, lowest goes out first
  localparam int unsigned NUM_SLOTS    = 5;
  localparam int unsigned SLOT_FOOT_TB = 0;
  localparam int unsigned SLOT_FOOT_BC = 1;
  localparam int unsigned SLOT_DIRECT  = 2;
  localparam int unsigned SLOT_HEAD_TB = 3;
  localparam int unsigned SLOT_HEAD_BC = 4;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

endpackage

[sv/unaligned_transfer_splitter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unaligned_transfer_splitter_top
// Splits one copy request into the ordered engine and bounce-buffer
// operations: foot, middle and head pieces for equal line offsets, one padded
// engine copy plus one byte copy for differing offsets, a none op for zero.
// ----------------------------------------------------------------------------
// datapath: the first operation of a request passes the plan register, then
//   the output register
// flow: one operation per cycle while the output is not stalled; a request
//   holds the plan register until its operations (1 to 5) have moved on, the next request
//   enters in the cycle its last operation moves to the output register
// reset: asynchronous, active low; clears the plan slots and output valid
module unaligned_transfer_splitter_top #(
  parameter int unsigned LINE_BYTES   = 128,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // source_address[47:0], target_address[95:48], byte_count[127:96],
  // transfer_flags[135:128]
  input  logic [uts_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // operation side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // op_source[47:0], op_target[95:48], op_length[128:96],
  // op_flags[136:129], zero[143:137]
  output logic [uts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // op_kind[1:0]
  output logic [uts_pkg::KIND_W-1:0]          m_axis_tuser_o,
  // last_op
  output logic                                m_axis_tlast_o
);

  localparam int unsigned LB = $clog2(LINE_BYTES);
  localparam int unsigned AW = (ADDRESS_BITS < uts_pkg::ADDR_W) ? ADDRESS_BITS
                                                                : uts_pkg::ADDR_W;
  localparam logic [uts_pkg::ADDR_W-1:0] AMASK  = {uts_pkg::ADDR_W{1'b1}} >>
                                                  (uts_pkg::ADDR_W - AW);
  localparam logic [uts_pkg::ADDR_W-1:0] LMASK_A = uts_pkg::ADDR_W'(LINE_BYTES - 1);
  localparam logic [uts_pkg::OPLEN_W-1:0] LINE_L = uts_pkg::OPLEN_W'(LINE_BYTES);
  localparam logic [uts_pkg::OPLEN_W-1:0] LMASK_L = uts_pkg::OPLEN_W'(LINE_BYTES - 1);

  // request unpack
  logic [uts_pkg::ADDR_W-1:0]  in_src, in_dst;
  logic [uts_pkg::COUNT_W-1:0] in_len;
  logic [uts_pkg::FLAGS_W-1:0] in_flags;

  assign in_src   = s_axis_tdata_i[47:0] & AMASK;
  assign in_dst   = s_axis_tdata_i[95:48] & AMASK;
  assign in_len   = s_axis_tdata_i[127:96];
  assign in_flags = s_axis_tdata_i[135:128];

  // plan of the incoming request
  logic [LB-1:0]               in_off;
  logic                        in_same, in_zero, in_has_off, in_merge;
  logic [LB:0]                 in_room;
  logic [uts_pkg::COUNT_W-1:0] head0, rem, mid, at_ofs, head_len;
  logic [LB-1:0]               foot;
  logic [uts_pkg::OPLEN_W-1:0] head_eng, eng_un;
  uts_pkg::slot_mask_t         in_mask;

  always_comb begin
    in_off     = in_src[LB-1:0];
    in_same    = (in_off == in_dst[LB-1:0]);
    in_zero    = (in_len == '0);
    in_has_off = (in_off != '0);
    in_room    = (LB+1)'(LINE_BYTES) - {1'b0, in_off};
    // head piece up to the first line boundary
    if (!in_has_off) begin
      head0 = '0;
    end else if (in_len > uts_pkg::COUNT_W'(in_room)) begin
      head0 = uts_pkg::COUNT_W'(in_room);
    end else begin
      head0 = in_len;
    end
    rem      = in_len - head0;
    foot     = rem[LB-1:0];
    mid      = {rem[uts_pkg::COUNT_W-1:LB], {LB{1'b0}}};
    in_merge = (rem != '0) && (rem[uts_pkg::COUNT_W-1:LB] == '0);
    at_ofs   = in_len - uts_pkg::COUNT_W'(foot);
    head_len = in_merge ? in_len : head0;
    head_eng = (in_has_off ? LINE_L : '0) + (in_merge ? LINE_L : '0);
    // padded engine copy for differing offsets, always one extra line
    eng_un   = (({1'b0, in_len} + uts_pkg::OPLEN_W'(in_off)) & ~LMASK_L) + LINE_L;
    // which operations this request needs
    in_mask = '0;
    if (in_zero) begin
      in_mask[uts_pkg::SLOT_HEAD_BC] = 1'b1;
    end else if (in_same) begin
      in_mask[uts_pkg::SLOT_FOOT_TB] = !in_merge && (foot != '0);
      in_mask[uts_pkg::SLOT_FOOT_BC] = !in_merge && (foot != '0);
      in_mask[uts_pkg::SLOT_DIRECT]  = (mid != '0);
      in_mask[uts_pkg::SLOT_HEAD_TB] = (head_len != '0);
      in_mask[uts_pkg::SLOT_HEAD_BC] = (head_len != '0);
    end else begin
      in_mask[uts_pkg::SLOT_HEAD_TB] = 1'b1;
      in_mask[uts_pkg::SLOT_HEAD_BC] = 1'b1;
    end
  end

  // plan register
  uts_pkg::slot_mask_t         mask_q, mask_d;
  logic [uts_pkg::ADDR_W-1:0]  src_q, dst_q;
  logic [LB-1:0]               off_q, foot_q;
  logic [uts_pkg::COUNT_W-1:0] at_q, head_q, mid_q;
  logic [uts_pkg::OPLEN_W-1:0] eng_q;
  logic [uts_pkg::FLAGS_W-1:0] flags_q;
  logic                        zero_q;

  // emission select, lowest pending slot first
  uts_pkg::slot_mask_t         sel, rest;
  logic                        out_move, in_take, sel_last;
  logic [uts_pkg::COUNT_W-1:0] ofs;
  logic [uts_pkg::ADDR_W-1:0]  src_sum, dst_sum;

  assign sel      = mask_q & (~mask_q + uts_pkg::slot_mask_t'(1));
  assign rest     = mask_q & ~sel;
  assign sel_last = (rest == '0);
  assign out_move = (mask_q != '0) && (!m_axis_tvalid_o || m_axis_tready_i);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (mask_q == '0) || (out_move && sel_last);

  always_comb begin
    if (in_take) begin
      mask_d = in_mask;
    end else if (out_move) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      src_q   <= in_src;
      dst_q   <= in_dst;
      off_q   <= in_off;
      foot_q  <= foot;
      at_q    <= at_ofs;
      mid_q   <= mid;
      head_q  <= in_same ? head_len : in_len;
      eng_q   <= in_same ? head_eng : eng_un;
      flags_q <= in_flags;
      zero_q  <= in_zero;
    end
  end

  // operation fields of the selected slot
  uts_pkg::op_kind_e           kind_d;
  logic [uts_pkg::ADDR_W-1:0]  osrc_d, otgt_d;
  logic [uts_pkg::OPLEN_W-1:0] olen_d;

  assign ofs     = (sel[uts_pkg::SLOT_FOOT_TB] || sel[uts_pkg::SLOT_FOOT_BC]) ? at_q : head_q;
  assign src_sum = (src_q + uts_pkg::ADDR_W'(ofs)) & AMASK;
  assign dst_sum = (dst_q + uts_pkg::ADDR_W'(ofs)) & AMASK;

  always_comb begin
    kind_d = uts_pkg::OP_NONE;
    osrc_d = '0;
    otgt_d = '0;
    olen_d = '0;
    priority if (sel[uts_pkg::SLOT_FOOT_TB]) begin
      kind_d = uts_pkg::OP_TO_BOUNCE;
      osrc_d = src_sum;
      olen_d = LINE_L;
    end else if (sel[uts_pkg::SLOT_FOOT_BC]) begin
      kind_d = uts_pkg::OP_BYTE_COPY;
      otgt_d = dst_sum;
      olen_d = uts_pkg::OPLEN_W'(foot_q);
    end else if (sel[uts_pkg::SLOT_DIRECT]) begin
      kind_d = uts_pkg::OP_DIRECT;
      osrc_d = src_sum;
      otgt_d = dst_sum;
      olen_d = uts_pkg::OPLEN_W'(mid_q);
    end else if (sel[uts_pkg::SLOT_HEAD_TB]) begin
      kind_d = uts_pkg::OP_TO_BOUNCE;
      osrc_d = src_q & ~LMASK_A;
      olen_d = eng_q;
    end else if (sel[uts_pkg::SLOT_HEAD_BC] && !zero_q) begin
      kind_d = uts_pkg::OP_BYTE_COPY;
      osrc_d = uts_pkg::ADDR_W'(off_q);
      otgt_d = dst_q;
      olen_d = uts_pkg::OPLEN_W'(head_q);
    end else begin
      // zero-length request: none op with cleared fields
      kind_d = uts_pkg::OP_NONE;
    end
  end

  // output register
  logic                        ovalid_q, ovalid_d;
  uts_pkg::op_kind_e           kind_q;
  logic [uts_pkg::ADDR_W-1:0]  osrc_q, otgt_q;
  logic [uts_pkg::OPLEN_W-1:0] olen_q;
  logic [uts_pkg::FLAGS_W-1:0] oflags_q;
  logic                        olast_q;

  assign ovalid_d = out_move || (ovalid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      kind_q   <= kind_d;
      osrc_q   <= osrc_d;
      otgt_q   <= otgt_d;
      olen_q   <= olen_d;
      oflags_q <= flags_q;
      olast_q  <= sel_last;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {7'd0, oflags_q, olen_q, otgt_q, osrc_q};

endmodule

[sv/uts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_checker
// Port-level checks of the unaligned transfer splitter operation stream,
// attached to the top level by bind.
// ----------------------------------------------------------------------------
module uts_checker #(
  parameter int unsigned LINE_BYTES = 128
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [uts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [uts_pkg::KIND_W-1:0]      m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);

  localparam int unsigned LB = $clog2(LINE_BYTES);

  logic [uts_pkg::OPLEN_W-1:0] op_len;
  logic [uts_pkg::ADDR_W-1:0]  op_tgt;

  assign op_len = m_axis_tdata_o[128:96];
  assign op_tgt = m_axis_tdata_o[95:48];

  // a stalled operation holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("operation changed while stalled");

  // engine copy to bounce is never the final op and has target zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == uts_pkg::OP_TO_BOUNCE) |->
      !m_axis_tlast_o && (op_tgt == '0))
    else $error("bounce fill op marked last or with nonzero target");

  // engine operations move whole lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == uts_pkg::OP_TO_BOUNCE) ||
                        (m_axis_tuser_o == uts_pkg::OP_DIRECT)) |->
      (op_len[LB-1:0] == '0) && (op_len != '0))
    else $error("engine op length not whole lines");

  // a none op stands alone with zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == uts_pkg::OP_NONE) |->
      m_axis_tlast_o && (op_len == '0))
    else $error("none op not last or not empty");

  // a bounce fill is followed by its byte copy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i &&
      (m_axis_tuser_o == uts_pkg::OP_TO_BOUNCE) |=>
      !m_axis_tvalid_o || (m_axis_tuser_o == uts_pkg::OP_BYTE_COPY))
    else $error("bounce fill not followed by byte copy");

endmodule

bind unaligned_transfer_splitter_top uts_checker #(
  .LINE_BYTES(LINE_BYTES)
) u_uts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[dv/unaligned_transfer_splitter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unaligned_transfer_splitter_top_tb
// Drives copy requests into the splitter and checks every emitted operation
// against an in-bench prediction of the split: zero length, same line offset
// (foot, middle, head, merged head and foot) and cross offset (padded engine
// copy plus byte copy), with address wrap, bursty requests and output stalls.
// ----------------------------------------------------------------------------
module unaligned_transfer_splitter_top_tb;

  localparam logic [63:0] LINE  = 64'd128;
  localparam logic [63:0] LMASK = LINE - 64'd1;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DIR_N = 21;

  // one operation as seen on the output stream
  typedef struct packed {
    uts_pkg::op_kind_e kind;
    logic [47:0]       src;
    logic [47:0]       dst;
    logic [32:0]       len;
    logic [7:0]        flags;
    logic              last;
  } op_t;

  // directed request, with up to two typed operations where obvious
  typedef struct {
    logic [47:0] src;
    logic [47:0] dst;
    logic [31:0] cnt;
    logic [7:0]  flags;
    int          golden_n;
    op_t         golden0;
    op_t         golden1;
  } stim_row_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_CADENCE} sink_mode_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [uts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [uts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [uts_pkg::KIND_W-1:0]      m_axis_tuser_o;
  logic                            m_axis_tlast_o;

  op_t        owed_ops [$];
  stim_row_t  dir_rows [DIR_N];
  op_t        seen_op;
  op_t        owed_head;
  int         mismatch_cnt = 0;
  int         ops_checked = 0;
  int         zero_reqs = 0;
  int         same_reqs = 0;
  int         cross_reqs = 0;
  sink_mode_e sink_mode = SINK_OPEN;
  logic       hold_go = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         sink_tick = 0;

  unaligned_transfer_splitter_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // queue one predicted operation, addresses wrap to 48 bits
  function automatic void note_op(input uts_pkg::op_kind_e kind, input logic [63:0] src,
                                  input logic [63:0] dst, input logic [63:0] len,
                                  input logic [7:0] flags);
    op_t op;
    op.kind  = kind;
    op.src   = src[47:0];
    op.dst   = dst[47:0];
    op.len   = len[32:0];
    op.flags = flags;
    op.last  = 1'b0;
    owed_ops.push_back(op);
  endfunction

  // operations that one copy request splits into
  function automatic void split_request(input logic [47:0] src_a, input logic [47:0] dst_a,
                                        input logic [31:0] cnt, input logic [7:0] flags);
    logic [63:0] src, dst, len, soff, doff, room, head_len, head_eng, foot_len, at, eng;
    op_t tail;
    src  = {16'd0, src_a};
    dst  = {16'd0, dst_a};
    len  = {32'd0, cnt};
    soff = src & LMASK;
    doff = dst & LMASK;
    if (len == 0) begin
      note_op(uts_pkg::OP_NONE, 64'd0, 64'd0, 64'd0, flags);
    end else if (soff == doff) begin
      head_len = 0;
      head_eng = 0;
      foot_len = 0;
      // partial first line
      if (soff != 0) begin
        room     = LINE - soff;
        head_len = (len > room) ? room : len;
        head_eng = LINE;
      end
      // partial last line, merged into the head when no middle remains
      if (len > head_len) begin
        foot_len = (len - head_len) & LMASK;
        if (len - foot_len == head_len) begin
          head_len = head_len + foot_len;
          head_eng = head_eng + LINE;
        end else if (foot_len > 0) begin
          at = len - foot_len;
          note_op(uts_pkg::OP_TO_BOUNCE, src + at, 64'd0, LINE, flags);
          note_op(uts_pkg::OP_BYTE_COPY, 64'd0, dst + at, foot_len, flags);
        end
      end
      if (len > head_len + foot_len)
        note_op(uts_pkg::OP_DIRECT, src + head_len, dst + head_len,
                len - head_len - foot_len, flags);
      if (head_len > 0) begin
        note_op(uts_pkg::OP_TO_BOUNCE, src & ~LMASK, 64'd0, head_eng, flags);
        note_op(uts_pkg::OP_BYTE_COPY, soff, dst, head_len, flags);
      end
    end else begin
      // padded to whole lines plus one spare line
      eng = len + soff;
      eng = eng + LINE - (eng & LMASK);
      note_op(uts_pkg::OP_TO_BOUNCE, src & ~LMASK, 64'd0, eng, flags);
      note_op(uts_pkg::OP_BYTE_COPY, soff, dst, len, flags);
    end
    tail = owed_ops.pop_back();
    tail.last = 1'b1;
    owed_ops.push_back(tail);
  endfunction

  // offer one request and hold it until taken; predict on acceptance
  task automatic offer_request(input logic [47:0] src, input logic [47:0] dst,
                               input logic [31:0] cnt, input logic [7:0] flags,
                               input bit predict);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {flags, cnt, dst, src};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cnt == 0) zero_reqs++;
    else if (src[6:0] == dst[6:0]) same_reqs++;
    else cross_reqs++;
    if (predict) split_request(src, dst, cnt, flags);
  endtask

  task automatic idle_source(input int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (owed_ops.size() != 0) @(posedge clk_i);
  endtask

  // random request, mostly meaningful splits, some raw noise
  task automatic offer_random();
    logic [63:0] ra, rb;
    logic [47:0] src, dst;
    logic [31:0] cnt;
    int pick;
    ra  = {$urandom(), $urandom()};
    rb  = {$urandom(), $urandom()};
    src = ra[47:0];
    dst = rb[47:0];
    pick = $urandom_range(0, 9);
    if (pick < 6) cnt = $urandom_range(1, 700);
    else if (pick < 8) cnt = 128 * $urandom_range(1, 4) + $urandom_range(0, 2);
    else cnt = $urandom();
    if ($urandom_range(0, 99) < 8) cnt = '0;
    // line offset shape
    pick = $urandom_range(0, 9);
    if (pick < 2) src[6:0] = '0;
    else if (pick < 4) src[6:0] = 7'h7F - 7'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) src[47:16] = '1;
    if ($urandom_range(0, 99) < 55) dst[6:0] = src[6:0];
    offer_request(src, dst, cnt, 8'($urandom()), 1'b1);
  endtask

  // random requests sent in bursts with optional gaps
  task automatic run_random(input int n, input bit gaps);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        offer_random();
        burst--;
        n--;
      end
      if (gaps && $urandom_range(0, 3) != 0) idle_source($urandom_range(1, 6));
    end
  endtask

  // receiver stall patterns, with a counted long hold-off on request
  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 1;
    if (hold_go != hold_seen) begin
      hold_seen       <= hold_go;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:   m_axis_tready_i <= 1'b1;
        SINK_RANDOM: m_axis_tready_i <= ($urandom_range(0, 9) < 7);
        default:     m_axis_tready_i <= ((sink_tick % 7) < 4);
      endcase
    end
  end

  // compare each taken operation with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_op.kind  = uts_pkg::op_kind_e'(m_axis_tuser_o);
      seen_op.src   = m_axis_tdata_o[47:0];
      seen_op.dst   = m_axis_tdata_o[95:48];
      seen_op.len   = m_axis_tdata_o[128:96];
      seen_op.flags = m_axis_tdata_o[136:129];
      seen_op.last  = m_axis_tlast_o;
      ops_checked++;
      if (owed_ops.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected op: kind=%0d src=%h dst=%h len=%h flags=%h last=%b",
                   seen_op.kind, seen_op.src, seen_op.dst, seen_op.len, seen_op.flags,
                   seen_op.last);
      end else begin
        owed_head = owed_ops.pop_front();
        if (seen_op.kind !== owed_head.kind || seen_op.src !== owed_head.src ||
            seen_op.dst !== owed_head.dst || seen_op.len !== owed_head.len ||
            seen_op.flags !== owed_head.flags || seen_op.last !== owed_head.last ||
            m_axis_tdata_o[143:137] !== '0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("op mismatch at %0t", $realtime);
            $display("  got  kind=%0d src=%h dst=%h len=%h flags=%h last=%b pad=%h",
                     seen_op.kind, seen_op.src, seen_op.dst, seen_op.len, seen_op.flags,
                     seen_op.last, m_axis_tdata_o[143:137]);
            $display("  want kind=%0d src=%h dst=%h len=%h flags=%h last=%b",
                     owed_head.kind, owed_head.src, owed_head.dst, owed_head.len,
                     owed_head.flags, owed_head.last);
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    dir_rows = '{
      // zero length at the address extremes
      '{48'hFFFF_FFFF_FFFF, 48'h0, 32'h0, 8'hFF, 1,
        '{uts_pkg::OP_NONE, 48'h0, 48'h0, 33'h0, 8'hFF, 1'b1}, '0},
      '{48'h0, 48'hFFFF_FFFF_FFFF, 32'h0, 8'h00, 1,
        '{uts_pkg::OP_NONE, 48'h0, 48'h0, 33'h0, 8'h00, 1'b1}, '0},
      // cross offset, single byte
      '{48'h1, 48'h2, 32'h1, 8'h5A, 2,
        '{uts_pkg::OP_TO_BOUNCE, 48'h0, 48'h0, 33'h80, 8'h5A, 1'b0},
        '{uts_pkg::OP_BYTE_COPY, 48'h1, 48'h2, 33'h1, 8'h5A, 1'b1}},
      // cross offset, padded length already on a line boundary gets a spare line
      '{48'h0, 48'h1, 32'h80, 8'h00, 2,
        '{uts_pkg::OP_TO_BOUNCE, 48'h0, 48'h0, 33'h100, 8'h00, 1'b0},
        '{uts_pkg::OP_BYTE_COPY, 48'h0, 48'h1, 33'h80, 8'h00, 1'b1}},
      // aligned whole line, direct only
      '{48'h1000, 48'h2000, 32'h80, 8'h3C, 1,
        '{uts_pkg::OP_DIRECT, 48'h1000, 48'h2000, 33'h80, 8'h3C, 1'b1}, '0},
      // same offset: head only, merged head and foot, all five pieces, foot plus direct
      '{48'h10, 48'h210, 32'h5, 8'hA5, 0, '0, '0},
      '{48'h70, 48'h4F0, 32'h20, 8'h81, 0, '0, '0},
      '{48'h1_0010, 48'h2_0010, 32'h205, 8'h7E, 0, '0, '0},
      '{48'h80, 48'h100, 32'h85, 8'h01, 0, '0, '0},
      '{48'h7F, 48'hFF, 32'h1, 8'h02, 0, '0, '0},
      '{48'h7F, 48'hFF, 32'h2, 8'h04, 0, '0, '0},
      // maximum byte count, both offset relations
      '{48'h40, 48'h1C0, 32'hFFFF_FFFF, 8'hFF, 0, '0, '0},
      '{48'h7F, 48'h0, 32'hFFFF_FFFF, 8'h80, 0, '0, '0},
      // address wrap at the top of the space
      '{48'hFFFF_FFFF_FF90, 48'h10, 32'h1000, 8'h10, 0, '0, '0},
      '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE, 32'h300, 8'h20, 0, '0, '0},
      '{48'hFFFF_FFFF_FF80, 48'hFFFF_FFFF_FF80, 32'h200, 8'h40, 0, '0, '0},
      // alternating bit patterns
      '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAD5, 32'h5555_5555, 8'h55, 0, '0, '0},
      '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 8'hAA, 0, '0, '0},
      // same offset: single byte merge, direct plus foot, head fills line exactly
      '{48'h0, 48'h0, 32'h1, 8'h0F, 0, '0, '0},
      '{48'h100, 48'h300, 32'h17F, 8'hF0, 0, '0, '0},
      '{48'h3C, 48'h3C, 32'h44, 8'hC3, 0, '0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, typed rows carry their own expectation
    foreach (dir_rows[i]) begin
      offer_request(dir_rows[i].src, dir_rows[i].dst, dir_rows[i].cnt, dir_rows[i].flags,
                    dir_rows[i].golden_n == 0);
      if (dir_rows[i].golden_n >= 1) owed_ops.push_back(dir_rows[i].golden0);
      if (dir_rows[i].golden_n >= 2) owed_ops.push_back(dir_rows[i].golden1);
    end
    idle_source(0);
    wait_drained();

    // random with a stalling receiver
    sink_mode <= SINK_RANDOM;
    run_random(90, 1'b1);

    // long receiver hold-off while requests keep coming back to back
    hold_go <= ~hold_go;
    run_random(20, 1'b0);
    idle_source(0);
    wait_drained();

    // fixed stall cadence, then a stretch with no idling on either side
    sink_mode <= SINK_CADENCE;
    run_random(80, 1'b1);
    sink_mode <= SINK_OPEN;
    run_random(80, 1'b0);
    idle_source(0);

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("requests: %0d zero length, %0d same offset, %0d cross offset",
             zero_reqs, same_reqs, cross_reqs);
    $display("operations checked: %0d, mismatches: %0d", ops_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("timeout with %0d operations outstanding", owed_ops.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
